/* rtl/qalu_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// qalu_pkg
// Shared types for the quaternion arithmetic unit: operation codes and the
// control bundle that moves along the pipeline with every beat.
// ----------------------------------------------------------------------------
package qalu_pkg;

    typedef enum logic [2:0] {
        OP_ADD       = 3'd0,
        OP_SUB       = 3'd1,
        OP_MUL       = 3'd2,
        OP_CONJ      = 3'd3,
        OP_NORM      = 3'd4,
        OP_NORMALIZE = 3'd5,
        OP_INVERSE   = 3'd6
    } op_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } ctl_t;

endpackage : qalu_pkg
`default_nettype wire

/* rtl/qalu_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// qalu_front
// Two-stage front end: products and squares, then the sum of squares and
// saturating add/sub/conj/Hamilton product or divide magnitudes and signs.
// ----------------------------------------------------------------------------
module qalu_front #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire qalu_pkg::ctl_t   ctl_in,
    input  wire logic [4*W-1:0]   a_in,
    input  wire logic [4*W-1:0]   b_in,
    output qalu_pkg::ctl_t        ctl_out,
    output logic [2*W:0]          s_out,
    output logic [4*W+5:0]        side_out
);
    import qalu_pkg::*;

    localparam int PW = 2 * W;
    localparam int HW = 2 * W + 2;
    localparam int SW = 2 * W + 1;
    localparam logic signed [HW-1:0] ROUND_HALF = HW'(1) << (F - 1);
    // lanes: scalar, i, j, k; a set bit subtracts that term
    localparam logic [3:0] MUL_NEG [4] = '{4'b1110, 4'b1000, 4'b1000, 4'b1000};

    logic signed [W-1:0]  a_in_l [4];
    logic signed [W-1:0]  b_in_l [4];
    ctl_t                 ctl1_reg;
    logic signed [W-1:0]  a_reg [4];
    logic signed [W-1:0]  b_reg [4];
    logic signed [PW-1:0] p_reg [4][4];
    logic signed [PW-1:0] p_next [4][4];
    logic [PW-1:0]        sq_reg [4];
    logic [PW-1:0]        sq_next [4];

    ctl_t                 ctl2_reg;
    logic [SW-1:0]        s_reg;
    logic [SW-1:0]        s_next;
    logic [4*W+5:0]       side_reg;
    logic [4*W+5:0]       side_next;
    logic [W-1:0]         r_lane [4];
    logic [3:0]           ov_lane;
    logic [3:0]           neg_lane;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            a_in_l[i] = a_in[i*W +: W];
            b_in_l[i] = b_in[i*W +: W];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            sq_next[i] = PW'(a_in_l[i]) * PW'(a_in_l[i]);
        end
        p_next[0][0] = PW'(a_in_l[0]) * PW'(b_in_l[0]);
        p_next[0][1] = PW'(a_in_l[1]) * PW'(b_in_l[1]);
        p_next[0][2] = PW'(a_in_l[2]) * PW'(b_in_l[2]);
        p_next[0][3] = PW'(a_in_l[3]) * PW'(b_in_l[3]);
        p_next[1][0] = PW'(a_in_l[0]) * PW'(b_in_l[1]);
        p_next[1][1] = PW'(b_in_l[0]) * PW'(a_in_l[1]);
        p_next[1][2] = PW'(a_in_l[2]) * PW'(b_in_l[3]);
        p_next[1][3] = PW'(b_in_l[2]) * PW'(a_in_l[3]);
        p_next[2][0] = PW'(a_in_l[0]) * PW'(b_in_l[2]);
        p_next[2][1] = PW'(b_in_l[0]) * PW'(a_in_l[2]);
        p_next[2][2] = PW'(a_in_l[3]) * PW'(b_in_l[1]);
        p_next[2][3] = PW'(b_in_l[3]) * PW'(a_in_l[1]);
        p_next[3][0] = PW'(a_in_l[0]) * PW'(b_in_l[3]);
        p_next[3][1] = PW'(b_in_l[0]) * PW'(a_in_l[3]);
        p_next[3][2] = PW'(a_in_l[1]) * PW'(b_in_l[2]);
        p_next[3][3] = PW'(b_in_l[1]) * PW'(a_in_l[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
        end
        else
        begin
            ctl1_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg  <= a_in_l;
        b_reg  <= b_in_l;
        p_reg  <= p_next;
        sq_reg <= sq_next;
    end

    always_comb
    begin
        s_next = SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]) + SW'(sq_reg[3]);
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        logic signed [HW-1:0] acc;
        logic signed [HW-1:0] shr;
        logic                 mul_fit;
        logic [W-1:0]         mul_val;
        logic [W:0]           sum_ab;
        logic [W:0]           dif_ab;
        logic [W:0]           neg_a;
        logic [W-1:0]         mag_a;

        always_comb
        begin
            acc = ROUND_HALF;
            for (int t = 0; t < 4; t++)
            begin
                if (MUL_NEG[g][t])
                    acc = acc - HW'(p_reg[g][t]);
                else
                    acc = acc + HW'(p_reg[g][t]);
            end
            shr     = acc >>> F;
            mul_fit = (&shr[HW-1:W-1]) | ~(|shr[HW-1:W-1]);
            mul_val = mul_fit ? shr[W-1:0] : {shr[HW-1], {(W-1){~shr[HW-1]}}};
            sum_ab  = {a_reg[g][W-1], a_reg[g]} + {b_reg[g][W-1], b_reg[g]};
            dif_ab  = {a_reg[g][W-1], a_reg[g]} - {b_reg[g][W-1], b_reg[g]};
            neg_a   = -{a_reg[g][W-1], a_reg[g]};
            mag_a   = a_reg[g][W-1] ? neg_a[W-1:0] : a_reg[g];

            r_lane[g]   = '0;
            ov_lane[g]  = 1'b0;
            neg_lane[g] = 1'b0;
            case (ctl1_reg.op)
                OP_ADD:
                begin
                    ov_lane[g] = sum_ab[W] ^ sum_ab[W-1];
                    r_lane[g]  = ov_lane[g] ? {sum_ab[W], {(W-1){~sum_ab[W]}}}
                                            : sum_ab[W-1:0];
                end
                OP_SUB:
                begin
                    ov_lane[g] = dif_ab[W] ^ dif_ab[W-1];
                    r_lane[g]  = ov_lane[g] ? {dif_ab[W], {(W-1){~dif_ab[W]}}}
                                            : dif_ab[W-1:0];
                end
                OP_MUL:
                begin
                    ov_lane[g] = ~mul_fit;
                    r_lane[g]  = mul_val;
                end
                OP_CONJ:
                begin
                    if (g == 0)
                    begin
                        r_lane[g] = a_reg[g];
                    end
                    else
                    begin
                        ov_lane[g] = neg_a[W] ^ neg_a[W-1];
                        r_lane[g]  = ov_lane[g] ? {neg_a[W], {(W-1){~neg_a[W]}}}
                                                : neg_a[W-1:0];
                    end
                end
                OP_NORMALIZE:
                begin
                    r_lane[g]   = mag_a;
                    neg_lane[g] = a_reg[g][W-1];
                end
                OP_INVERSE:
                begin
                    // conjugate flips the sign of the vector part
                    r_lane[g] = mag_a;
                    if (g == 0)
                        neg_lane[g] = a_reg[g][W-1];
                    else
                        neg_lane[g] = ~a_reg[g][W-1] && (a_reg[g] != '0);
                end
                default:
                begin
                    r_lane[g] = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        side_next[4*W+5] = ((ctl1_reg.op == OP_NORMALIZE) || (ctl1_reg.op == OP_INVERSE))
                           && (s_next == '0);
        side_next[4*W+4]       = |ov_lane;
        side_next[4*W+3:4*W]   = neg_lane;
        for (int i = 0; i < 4; i++)
        begin
            side_next[i*W +: W] = r_lane[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl2_reg <= '0;
        end
        else
        begin
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg    <= s_next;
        side_reg <= side_next;
    end

    assign ctl_out  = ctl2_reg;
    assign s_out    = s_reg;
    assign side_out = side_reg;

endmodule : qalu_front
`default_nettype wire

/* rtl/qalu_sqrt_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// qalu_sqrt_cell
// One digit of a restoring square root: takes two radicand bits, forms one
// root bit and hands the partial remainder and root to the next cell.
// ----------------------------------------------------------------------------
module qalu_sqrt_cell #(
    parameter int RW = 33,
    parameter int XW = 8
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire qalu_pkg::ctl_t  ctl_in,
    input  wire logic [2*RW-1:0] s_in,
    input  wire logic [RW+1:0]   rem_in,
    input  wire logic [RW-1:0]   root_in,
    input  wire logic [XW-1:0]   side_in,
    output qalu_pkg::ctl_t       ctl_out,
    output logic [2*RW-1:0]      s_out,
    output logic [RW+1:0]        rem_out,
    output logic [RW-1:0]        root_out,
    output logic [XW-1:0]        side_out
);
    import qalu_pkg::*;

    ctl_t             ctl_reg;
    logic [2*RW-1:0]  s_reg;
    logic [RW+1:0]    rem_reg;
    logic [RW+1:0]    rem_next;
    logic [RW-1:0]    root_reg;
    logic [RW-1:0]    root_next;
    logic [XW-1:0]    side_reg;
    logic [RW+3:0]    cur;
    logic [RW+3:0]    trial;
    logic             ge;

    always_comb
    begin
        cur       = {rem_in, s_in[2*RW-1 -: 2]};
        trial     = (RW+4)'({root_in, 2'b01});
        ge        = cur >= trial;
        rem_next  = ge ? (RW+2)'(cur - trial) : (RW+2)'(cur);
        root_next = {root_in[RW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg    <= s_in << 2;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        side_reg <= side_in;
    end

    assign ctl_out  = ctl_reg;
    assign s_out    = s_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign side_out = side_reg;

endmodule : qalu_sqrt_cell
`default_nettype wire

/* rtl/qalu_div_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// qalu_div_cell
// One quotient bit of a restoring divide, four lanes sharing one divisor.
// ----------------------------------------------------------------------------
module qalu_div_cell #(
    parameter int W  = 32,
    parameter int DW = 65,
    parameter int XW = 8
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire qalu_pkg::ctl_t  ctl_in,
    input  wire logic [DW-1:0]   d_in,
    input  wire logic [4*DW-1:0] rem_in,
    input  wire logic [4*W-1:0]  nlo_in,
    input  wire logic [4*W-1:0]  q_in,
    input  wire logic [XW-1:0]   side_in,
    output qalu_pkg::ctl_t       ctl_out,
    output logic [DW-1:0]        d_out,
    output logic [4*DW-1:0]      rem_out,
    output logic [4*W-1:0]       nlo_out,
    output logic [4*W-1:0]       q_out,
    output logic [XW-1:0]        side_out
);
    import qalu_pkg::*;

    ctl_t            ctl_reg;
    logic [DW-1:0]   d_reg;
    logic [4*DW-1:0] rem_reg;
    logic [4*DW-1:0] rem_next;
    logic [4*W-1:0]  nlo_reg;
    logic [4*W-1:0]  nlo_next;
    logic [4*W-1:0]  q_reg;
    logic [4*W-1:0]  q_next;
    logic [XW-1:0]   side_reg;

    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        logic [DW:0] rs;
        logic        ge;

        always_comb
        begin
            rs = {rem_in[g*DW +: DW], nlo_in[g*W + W - 1]};
            ge = rs >= {1'b0, d_in};
            rem_next[g*DW +: DW] = ge ? DW'(rs - {1'b0, d_in}) : DW'(rs);
            nlo_next[g*W +: W]   = nlo_in[g*W +: W] << 1;
            q_next[g*W +: W]     = {q_in[g*W +: W-1], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg    <= d_in;
        rem_reg  <= rem_next;
        nlo_reg  <= nlo_next;
        q_reg    <= q_next;
        side_reg <= side_in;
    end

    assign ctl_out  = ctl_reg;
    assign d_out    = d_reg;
    assign rem_out  = rem_reg;
    assign nlo_out  = nlo_reg;
    assign q_out    = q_reg;
    assign side_out = side_reg;

endmodule : qalu_div_cell
`default_nettype wire

/* rtl/quaternion_alu_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_alu_unit
// Fixed-point quaternion unit: add, subtract, Hamilton product, conjugate,
// norm, normalize and inverse, all saturating.
//
//   channel   ports                                   flow
//   command   start, busy, operation, a_*, b_*        in, taken when start && !busy
//   result    done, r_*, magnitude, overflow,         out, done high for a single cycle per beat
//             divide_by_zero
//
// One beat accepted every cycle; busy never rises. Each beat passes through
// two front stages, one root cell per root bit (COMPONENT_WIDTH+1), one
// setup stage, one divide cell per quotient bit (COMPONENT_WIDTH) and the
// output register. Reset clears only the control bundle (valid and op) of
// every stage and done, not the data. The receiver cannot stall; results
// leave in order of acceptance.
// ----------------------------------------------------------------------------
module quaternion_alu_unit #(
    parameter int COMPONENT_WIDTH = 32,
    parameter int FRACTION_BITS   = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [2:0]                        operation,
    input  wire logic signed [COMPONENT_WIDTH-1:0] a_scalar,
    input  wire logic signed [COMPONENT_WIDTH-1:0] a_i,
    input  wire logic signed [COMPONENT_WIDTH-1:0] a_j,
    input  wire logic signed [COMPONENT_WIDTH-1:0] a_k,
    input  wire logic signed [COMPONENT_WIDTH-1:0] b_scalar,
    input  wire logic signed [COMPONENT_WIDTH-1:0] b_i,
    input  wire logic signed [COMPONENT_WIDTH-1:0] b_j,
    input  wire logic signed [COMPONENT_WIDTH-1:0] b_k,
    output logic                                   done,
    output logic signed [COMPONENT_WIDTH-1:0]      r_scalar,
    output logic signed [COMPONENT_WIDTH-1:0]      r_i,
    output logic signed [COMPONENT_WIDTH-1:0]      r_j,
    output logic signed [COMPONENT_WIDTH-1:0]      r_k,
    output logic [COMPONENT_WIDTH-1:0]             magnitude,
    output logic                                   overflow,
    output logic                                   divide_by_zero
);
    import qalu_pkg::*;

    localparam int W   = COMPONENT_WIDTH;
    localparam int F   = FRACTION_BITS;
    localparam int SW  = 2 * W + 1;
    localparam int RW  = W + 1;
    localparam int DW  = SW;
    localparam int NW  = W + 2 * F;
    localparam int XW  = (2 * F > DW) ? 2 * F : DW;
    localparam int FSW = 4 * W + 6;
    localparam int QSW = SW + FSW;
    localparam int DSW = 4 * W + W + 10;

    ctl_t           in_ctl;
    ctl_t           fr_ctl;
    logic [SW-1:0]  fr_s;
    logic [FSW-1:0] fr_side;

    assign busy = 1'b0;

    always_comb
    begin
        in_ctl.valid = start && !busy;
        in_ctl.op    = op_t'(operation);
    end

    qalu_front #(.W(W), .F(F)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_in   (in_ctl),
        .a_in     ({a_k, a_j, a_i, a_scalar}),
        .b_in     ({b_k, b_j, b_i, b_scalar}),
        .ctl_out  (fr_ctl),
        .s_out    (fr_s),
        .side_out (fr_side)
    );

    // square root chain
    ctl_t            sq_ctl  [RW+1];
    logic [2*RW-1:0] sq_s    [RW+1];
    logic [RW+1:0]   sq_rem  [RW+1];
    logic [RW-1:0]   sq_root [RW+1];
    logic [QSW-1:0]  sq_side [RW+1];

    assign sq_ctl[0]  = fr_ctl;
    assign sq_s[0]    = {1'b0, fr_s};
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_side[0] = {fr_s, fr_side};

    for (genvar c = 0; c < RW; c++)
    begin : g_sqrt
        qalu_sqrt_cell #(.RW(RW), .XW(QSW)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl_in   (sq_ctl[c]),
            .s_in     (sq_s[c]),
            .rem_in   (sq_rem[c]),
            .root_in  (sq_root[c]),
            .side_in  (sq_side[c]),
            .ctl_out  (sq_ctl[c+1]),
            .s_out    (sq_s[c+1]),
            .rem_out  (sq_rem[c+1]),
            .root_out (sq_root[c+1]),
            .side_out (sq_side[c+1])
        );
    end

    // divide setup
    ctl_t            st_ctl;
    logic [SW-1:0]   st_s;
    logic [FSW-1:0]  st_fside;
    logic [RW-1:0]   st_root;
    logic [DW-1:0]   d_next;
    logic [4*DW-1:0] rem0_next;
    logic [4*W-1:0]  nlo0_next;
    logic [3:0]      big_next;
    logic [W-1:0]    mag_next;
    logic            mag_ov;
    logic [DSW-1:0]  dside_next;
    ctl_t            su_ctl_reg;
    logic [DW-1:0]   su_d_reg;
    logic [4*DW-1:0] su_rem_reg;
    logic [4*W-1:0]  su_nlo_reg;
    logic [DSW-1:0]  su_side_reg;

    assign st_ctl   = sq_ctl[RW];
    assign st_root  = sq_root[RW];
    assign st_s     = sq_side[RW][QSW-1:FSW];
    assign st_fside = sq_side[RW][FSW-1:0];

    for (genvar g = 0; g < 4; g++)
    begin : g_setup
        logic [NW-1:0]  num;
        logic [2*F-1:0] hi;

        always_comb
        begin
            if (st_ctl.op == OP_NORMALIZE)
                num = NW'(st_fside[g*W +: W]) << F;
            else
                num = NW'(st_fside[g*W +: W]) << (2 * F);
            hi          = num[NW-1:W];
            // quotient would not fit in W bits
            big_next[g] = XW'(hi) >= XW'(d_next);
            rem0_next[g*DW +: DW] = big_next[g] ? '0 : DW'(hi);
            nlo0_next[g*W +: W]   = num[W-1:0];
        end
    end

    always_comb
    begin
        d_next   = (st_ctl.op == OP_NORMALIZE) ? DW'(st_root) : st_s;
        mag_ov   = 1'b0;
        mag_next = '0;
        if (st_ctl.op == OP_NORM)
        begin
            mag_ov   = st_root[RW-1];
            mag_next = mag_ov ? '1 : st_root[W-1:0];
        end
        dside_next = {big_next, st_fside[4*W+3:4*W], mag_next,
                      st_fside[4*W+5], st_fside[4*W+4] | mag_ov, st_fside[4*W-1:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            su_ctl_reg <= '0;
        end
        else
        begin
            su_ctl_reg <= st_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        su_d_reg    <= d_next;
        su_rem_reg  <= rem0_next;
        su_nlo_reg  <= nlo0_next;
        su_side_reg <= dside_next;
    end

    // divide chain
    ctl_t            dv_ctl  [W+1];
    logic [DW-1:0]   dv_d    [W+1];
    logic [4*DW-1:0] dv_rem  [W+1];
    logic [4*W-1:0]  dv_nlo  [W+1];
    logic [4*W-1:0]  dv_q    [W+1];
    logic [DSW-1:0]  dv_side [W+1];

    assign dv_ctl[0]  = su_ctl_reg;
    assign dv_d[0]    = su_d_reg;
    assign dv_rem[0]  = su_rem_reg;
    assign dv_nlo[0]  = su_nlo_reg;
    assign dv_q[0]    = '0;
    assign dv_side[0] = su_side_reg;

    for (genvar c = 0; c < W; c++)
    begin : g_div
        qalu_div_cell #(.W(W), .DW(DW), .XW(DSW)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl_in   (dv_ctl[c]),
            .d_in     (dv_d[c]),
            .rem_in   (dv_rem[c]),
            .nlo_in   (dv_nlo[c]),
            .q_in     (dv_q[c]),
            .side_in  (dv_side[c]),
            .ctl_out  (dv_ctl[c+1]),
            .d_out    (dv_d[c+1]),
            .rem_out  (dv_rem[c+1]),
            .nlo_out  (dv_nlo[c+1]),
            .q_out    (dv_q[c+1]),
            .side_out (dv_side[c+1])
        );
    end

    // output stage
    ctl_t           ed_ctl;
    logic [DSW-1:0] ed_side;
    logic [3:0]     ed_big;
    logic [3:0]     ed_neg;
    logic           ed_dz;
    logic           ed_ovf;
    logic [W-1:0]   q_val   [4];
    logic [3:0]     q_ov;
    logic [W-1:0]   r_next  [4];
    logic [W-1:0]   mag_out_next;
    logic           ovf_next;
    logic           dz_next;
    logic           done_reg;
    logic [W-1:0]   r_reg   [4];
    logic [W-1:0]   mag_reg;
    logic           ovf_reg;
    logic           dz_reg;

    assign ed_ctl  = dv_ctl[W];
    assign ed_side = dv_side[W];
    assign ed_big  = ed_side[DSW-1 -: 4];
    assign ed_neg  = ed_side[DSW-5 -: 4];
    assign ed_dz   = ed_side[4*W+1];
    assign ed_ovf  = ed_side[4*W];

    for (genvar g = 0; g < 4; g++)
    begin : g_out
        logic [W-1:0] q;

        always_comb
        begin
            q = dv_q[W][g*W +: W];
            if (ed_neg[g])
                q_ov[g] = ed_big[g] | (q[W-1] & (|q[W-2:0]));
            else
                q_ov[g] = ed_big[g] | q[W-1];
            if (q_ov[g])
                q_val[g] = ed_neg[g] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            else
                q_val[g] = ed_neg[g] ? -q : q;
        end
    end

    always_comb
    begin
        mag_out_next = ed_side[4*W+2 +: W];
        ovf_next     = ed_ovf;
        dz_next      = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            r_next[i] = ed_side[i*W +: W];
        end
        if ((ed_ctl.op == OP_NORMALIZE) || (ed_ctl.op == OP_INVERSE))
        begin
            dz_next = ed_dz;
            for (int i = 0; i < 4; i++)
            begin
                r_next[i] = ed_dz ? '0 : q_val[i];
            end
            ovf_next = ~ed_dz & (|q_ov);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ed_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg   <= r_next;
        mag_reg <= mag_out_next;
        ovf_reg <= ovf_next;
        dz_reg  <= dz_next;
    end

    assign done           = done_reg;
    assign r_scalar       = r_reg[0];
    assign r_i            = r_reg[1];
    assign r_j            = r_reg[2];
    assign r_k            = r_reg[3];
    assign magnitude      = mag_reg;
    assign overflow       = ovf_reg;
    assign divide_by_zero = dz_reg;

endmodule : quaternion_alu_unit
`default_nettype wire

/* tb/quaternion_alu_unit_tb.sv */
// ----------------------------------------------------------------------------
// quaternion_alu_unit_tb
// Self-checking bench for the quaternion unit. Directed beats cover the
// extremes, every operation, saturation and the zero quaternion; random
// beats follow. Each accepted beat is predicted in place and every result
// is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module quaternion_alu_unit_tb;
    import qalu_pkg::*;

    localparam int CW = 32;
    localparam int FB = 16;
    localparam int LATENCY = 2 * CW + 5;
    localparam int STALL_LIMIT = 5000;
    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam logic signed [CW-1:0] QMAX = 32'sh7fffffff;
    localparam logic signed [CW-1:0] QMIN = 32'sh80000000;
    localparam logic signed [CW-1:0] QONE = 32'sh00010000;

    typedef struct packed {
        logic [2:0]           op;
        logic signed [CW-1:0] a0, a1, a2, a3;
        logic signed [CW-1:0] b0, b1, b2, b3;
    } quat_cmd_t;

    typedef struct packed {
        logic signed [CW-1:0] rs, ri, rj, rk;
        logic [CW-1:0]        mag;
        logic                 ovf;
        logic                 dz;
    } quat_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [2:0] operation = '0;
    logic signed [CW-1:0] a_scalar = '0, a_i = '0, a_j = '0, a_k = '0;
    logic signed [CW-1:0] b_scalar = '0, b_i = '0, b_j = '0, b_k = '0;
    logic busy, done, overflow, divide_by_zero;
    logic signed [CW-1:0] r_scalar, r_i, r_j, r_k;
    logic [CW-1:0] magnitude;

    quat_res_t pending_results[$];
    int mismatches = 0;
    int stall_cycles = 0;
    bit no_gaps = 1'b0;

    quaternion_alu_unit #(.COMPONENT_WIDTH(CW), .FRACTION_BITS(FB)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation),
        .a_scalar(a_scalar), .a_i(a_i), .a_j(a_j), .a_k(a_k),
        .b_scalar(b_scalar), .b_i(b_i), .b_j(b_j), .b_k(b_k),
        .done(done), .r_scalar(r_scalar), .r_i(r_i), .r_j(r_j), .r_k(r_k),
        .magnitude(magnitude), .overflow(overflow),
        .divide_by_zero(divide_by_zero)
    );

    always #6 clk = ~clk;

    function automatic logic signed [CW-1:0] clamp(input logic signed [127:0] v,
                                                   inout logic ovf);
        if (v > 128'sd2147483647) begin
            ovf = 1'b1;
            return QMAX;
        end
        if (v < -128'sd2147483648) begin
            ovf = 1'b1;
            return QMIN;
        end
        return v[CW-1:0];
    endfunction

    function automatic logic [127:0] int_sqrt(input logic [127:0] v);
        logic [127:0] res;
        logic [127:0] bitv;
        res = '0;
        bitv = 128'd1 << 126;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // truncated quotient of (mag << sh) / d with sign and saturation
    function automatic logic signed [CW-1:0] scaled_div(input logic [127:0] mag,
                                                        input int sh,
                                                        input logic [127:0] d,
                                                        input logic neg,
                                                        inout logic ovf);
        logic [127:0] q;
        logic [127:0] lim;
        q = (mag << sh) / d;
        lim = neg ? 128'd2147483648 : 128'd2147483647;
        if (q > lim) begin
            ovf = 1'b1;
            return neg ? QMIN : QMAX;
        end
        return neg ? -q[CW-1:0] : q[CW-1:0];
    endfunction

    function automatic quat_res_t predict_quat(input quat_cmd_t c);
        quat_res_t r;
        logic signed [127:0] a[4];
        logic signed [127:0] b[4];
        logic signed [127:0] acc;
        logic [127:0] ssum, root, m;
        logic ovf;
        logic neg;
        logic signed [CW-1:0] q[4];
        a[0] = c.a0; a[1] = c.a1; a[2] = c.a2; a[3] = c.a3;
        b[0] = c.b0; b[1] = c.b1; b[2] = c.b2; b[3] = c.b3;
        ovf = 1'b0;
        r = '0;
        for (int i = 0; i < 4; i++) q[i] = '0;
        ssum = '0;
        for (int i = 0; i < 4; i++) ssum = ssum + 128'(a[i] * a[i]);
        root = int_sqrt(ssum);
        case (c.op)
            OP_ADD: for (int i = 0; i < 4; i++) q[i] = clamp(a[i] + b[i], ovf);
            OP_SUB: for (int i = 0; i < 4; i++) q[i] = clamp(a[i] - b[i], ovf);
            OP_MUL: begin
                for (int i = 0; i < 4; i++) begin
                    case (i)
                        0: acc = a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3];
                        1: acc = a[0]*b[1] + b[0]*a[1] + a[2]*b[3] - b[2]*a[3];
                        2: acc = a[0]*b[2] + b[0]*a[2] + a[3]*b[1] - b[3]*a[1];
                        default: acc = a[0]*b[3] + b[0]*a[3] + a[1]*b[2] - b[1]*a[2];
                    endcase
                    acc = (acc + (128'sd1 <<< (FB - 1))) >>> FB;
                    q[i] = clamp(acc, ovf);
                end
            end
            OP_CONJ: begin
                q[0] = c.a0;
                for (int i = 1; i < 4; i++) q[i] = clamp(-a[i], ovf);
            end
            OP_NORM: begin
                if (root > 128'hffffffff) begin
                    ovf = 1'b1;
                    r.mag = '1;
                end else begin
                    r.mag = root[CW-1:0];
                end
            end
            OP_NORMALIZE: begin
                if (root == 0) r.dz = 1'b1;
                else for (int i = 0; i < 4; i++) begin
                    m = (a[i] < 0) ? 128'(-a[i]) : 128'(a[i]);
                    q[i] = scaled_div(m, FB, root, a[i] < 0, ovf);
                end
            end
            OP_INVERSE: begin
                if (ssum == 0) r.dz = 1'b1;
                else for (int i = 0; i < 4; i++) begin
                    m = (a[i] < 0) ? 128'(-a[i]) : 128'(a[i]);
                    neg = (i == 0) ? (a[i] < 0) : (a[i] > 0);
                    q[i] = scaled_div(m, 2 * FB, ssum, neg, ovf);
                end
            end
            default: ;
        endcase
        r.rs = q[0]; r.ri = q[1]; r.rj = q[2]; r.rk = q[3];
        r.ovf = ovf;
        return r;
    endfunction

    // result check, prediction on acceptance, stall watchdog
    always @(posedge clk) begin
        quat_res_t exp_r;
        quat_res_t got;
        quat_cmd_t cmd;
        if (done) begin
            got = '{r_scalar, r_i, r_j, r_k, magnitude, overflow, divide_by_zero};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", got);
            end else begin
                exp_r = pending_results.pop_front();
                if (got !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp r=%h %h %h %h mag=%h ovf=%b dz=%b / got r=%h %h %h %h mag=%h ovf=%b dz=%b",
                                 exp_r.rs, exp_r.ri, exp_r.rj, exp_r.rk, exp_r.mag,
                                 exp_r.ovf, exp_r.dz, got.rs, got.ri, got.rj, got.rk,
                                 got.mag, got.ovf, got.dz);
                end
            end
        end
        if (rst_n && start && !busy) begin
            cmd = '{operation, a_scalar, a_i, a_j, a_k, b_scalar, b_i, b_j, b_k};
            pending_results.push_back(predict_quat(cmd));
        end
        if (done || (rst_n && start && !busy)) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("quaternion_alu_unit_tb: FAIL");
            $finish;
        end
    end

    task automatic send_beat(input quat_cmd_t c);
        // unless no_gaps is set, an idle gap comes before about nine beats in a hundred
        if (!no_gaps && $urandom_range(0, 99) < 9) begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        {operation, a_scalar, a_i, a_j, a_k, b_scalar, b_i, b_j, b_k} <= c;
        do @(posedge clk); while (busy);
    endtask

    task automatic go_idle();
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    function automatic logic signed [CW-1:0] rand_comp();
        case ($urandom_range(0, 9))
            0: return QMIN;
            1: return QMAX;
            2: return '0;
            3: return $urandom_range(0, 1) ? QONE : -QONE;
            4, 5: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff;
            6: return $signed($urandom_range(0, 32'h3ffffff)) - 32'sh1ffffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic quat_cmd_t rand_cmd();
        quat_cmd_t c;
        c.op = ($urandom_range(0, 49) == 0) ? OP_UNUSED : 3'($urandom_range(0, 6));
        c.a0 = rand_comp(); c.a1 = rand_comp(); c.a2 = rand_comp(); c.a3 = rand_comp();
        c.b0 = rand_comp(); c.b1 = rand_comp(); c.b2 = rand_comp(); c.b3 = rand_comp();
        if ($urandom_range(0, 19) == 0) {c.a0, c.a1, c.a2, c.a3} = '0;
        return c;
    endfunction

    task automatic test_directed();
        logic [2:0] ops[8];
        ops = '{OP_ADD, OP_SUB, OP_MUL, OP_CONJ, OP_NORM, OP_NORMALIZE,
                OP_INVERSE, OP_UNUSED};
        // all-max and all-min operands through every operation
        foreach (ops[i]) send_beat('{ops[i], QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX});
        foreach (ops[i]) send_beat('{ops[i], QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN});
        // zero quaternion for normalize, inverse and norm
        send_beat('{OP_NORMALIZE, '0, '0, '0, '0, QONE, QONE, QONE, QONE});
        send_beat('{OP_INVERSE, '0, '0, '0, '0, QMIN, QMIN, QMIN, QMIN});
        send_beat('{OP_NORM, '0, '0, '0, '0, '0, '0, '0, '0});
        // unit, tiny and mixed extreme operands
        send_beat('{OP_MUL, QONE, QONE, -QONE, QONE, -QONE, QONE, QONE, -QONE});
        send_beat('{OP_INVERSE, 32'sd1, '0, '0, '0, '0, '0, '0, '0});
        send_beat('{OP_NORMALIZE, 32'sd1, -32'sd1, '0, '0, '0, '0, '0, '0});
        send_beat('{OP_CONJ, QMIN, QMIN, QMAX, '0, '0, '0, '0, '0});
        send_beat('{OP_ADD, QMAX, QMIN, 32'sd1, -32'sd1, 32'sd1, -32'sd1, QMAX, QMIN});
        send_beat('{OP_SUB, QMIN, QMAX, '0, -32'sd1, 32'sd1, -32'sd1, QMAX, QMIN});
        go_idle();
    endtask

    task automatic test_drain_pause();
        // hold the command side until the pipeline is empty
        send_beat(rand_cmd());
        go_idle();
        wait_drained();
        send_beat(rand_cmd());
        go_idle();
    endtask

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++) begin
            no_gaps = (n >= 300 && n < 500);
            send_beat(rand_cmd());
        end
        no_gaps = 1'b0;
        go_idle();
    endtask

    initial begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_drain_pause();
        test_random(1250);
        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("quaternion_alu_unit_tb: PASS");
        else
            $display("quaternion_alu_unit_tb: FAIL");
        $finish;
    end

endmodule

/* quaternion_alu_unit.f */
rtl/qalu_pkg.sv
rtl/qalu_front.sv
rtl/qalu_sqrt_cell.sv
rtl/qalu_div_cell.sv
rtl/quaternion_alu_unit.sv
tb/quaternion_alu_unit_tb.sv
